### hdl/sss_pkg.sv
// Shared types and constants of the sparse set store.
// Holds the status and mode codes, the result record and the write-enable group.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sss_pkg;

	// fixed widths of the request and result fields
	localparam int MODE_W   = 2;
	localparam int ENT_ID_W = 8;
	localparam int WORD_W   = 32;
	localparam int STATUS_W = 3;
	localparam int SLOT_W   = 8;
	localparam int COUNT_W  = 9;

	typedef enum logic [MODE_W-1:0] {
		MODE_ADD    = 2'd0,
		MODE_REMOVE = 2'd1,
		MODE_GET    = 2'd2
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_ADDED       = 3'd0,
		ST_OVERWRITTEN = 3'd1,
		ST_REMOVED     = 3'd2,
		ST_ABSENT      = 3'd3,
		ST_FOUND       = 3'd4,
		ST_FULL        = 3'd5
	} status_t;

	// one finished result as it leaves the commit stage
	typedef struct packed {
		status_t              status;
		logic [SLOT_W-1:0]    slot;
		logic [COUNT_W-1:0]   count;
	} result_t;

	// write strobes of the three memories
	typedef struct packed {
		logic sparse;
		logic owner;
		logic words;
	} wr_en_t;

endpackage

`default_nettype wire

### hdl/sss_ram.sv
// Generic RAM: one write port and two read ports, read data registered.
// Read during write of the same address returns the old word.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module sss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en_a,
	input  wire logic [AW-1:0]    rd_addr_a,
	output logic      [WIDTH-1:0] rd_data_a,
	input  wire logic             rd_en_b,
	input  wire logic [AW-1:0]    rd_addr_b,
	output logic      [WIDTH-1:0] rd_data_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write, and register both reads
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en_a) begin
			rd_data_a <= mem[rd_addr_a];
		end
		if (rd_en_b) begin
			rd_data_b <= mem[rd_addr_b];
		end
	end

endmodule

`default_nettype wire

### hdl/sss_admit.sv
// Admission stage: per-entity presence bits, held count and request decode.
// Decides the outcome of each request at the cycle it is taken.
// Depends on sss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sss_admit
	import sss_pkg::*;
#(
	parameter int CAPACITY = 256,
	localparam int ENT_N = (CAPACITY < 256) ? CAPACITY : 256,
	localparam int ENT_W = $clog2(ENT_N),
	localparam int IDX_W = $clog2(CAPACITY),
	localparam int CNT_W = $clog2(CAPACITY + 1)
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                accept,
	input  wire logic [MODE_W-1:0]   mode,
	input  wire logic [ENT_ID_W-1:0] entity_id,
	output status_t                  op,
	output logic      [ENT_W-1:0]    ent,
	output logic      [IDX_W-1:0]    slot_new,
	output logic      [IDX_W-1:0]    last,
	output logic      [CNT_W-1:0]    count_after
);

	localparam logic [16:0] CAP_L = 17'(CAPACITY);

	logic [ENT_N-1:0] present_q;
	logic [CNT_W-1:0] count_q;
	logic             in_range;
	logic             present;
	logic             full;

	// look up the entity and the fill level
	assign in_range = (17'(entity_id) < CAP_L);
	assign ent      = entity_id[ENT_W-1:0];
	assign present  = in_range && present_q[ent];
	assign full     = (count_q == CNT_W'(CAPACITY));
	assign slot_new = count_q[IDX_W-1:0];
	assign last     = IDX_W'(count_q - CNT_W'(1));

	// decide the outcome of the request
	always_comb begin
		op = ST_ABSENT;
		if (in_range) begin
			unique case (mode)
				MODE_ADD: begin
					if (present) begin
						op = ST_OVERWRITTEN;
					end else if (full) begin
						op = ST_FULL;
					end else begin
						op = ST_ADDED;
					end
				end
				MODE_REMOVE: begin
					if (present) begin
						op = ST_REMOVED;
					end
				end
				MODE_GET: begin
					if (present) begin
						op = ST_FOUND;
					end
				end
				default: op = ST_ABSENT;
			endcase
		end
	end

	// count after this request
	always_comb begin
		case (op)
			ST_ADDED:   count_after = count_q + CNT_W'(1);
			ST_REMOVED: count_after = count_q - CNT_W'(1);
			default:    count_after = count_q;
		endcase
	end

	// advance presence bits and count on each taken request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
			count_q   <= '0;
		end else if (accept) begin
			count_q <= count_after;
			if (op == ST_ADDED) begin
				present_q[ent] <= 1'b1;
			end else if (op == ST_REMOVED) begin
				present_q[ent] <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

### hdl/sss_commit.sv
// Commit stage: holds one decoded request, merges memory read data with the
// previous write, and issues the memory writes of that request.
// Depends on sss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sss_commit
	import sss_pkg::*;
#(
	parameter int CAPACITY = 256,
	parameter int DATA_WIDTH = 32,
	localparam int ENT_N = (CAPACITY < 256) ? CAPACITY : 256,
	localparam int ENT_W = $clog2(ENT_N),
	localparam int IDX_W = $clog2(CAPACITY),
	localparam int CNT_W = $clog2(CAPACITY + 1)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  load,
	input  wire logic                  fire,
	input  wire status_t               op_in,
	input  wire logic [ENT_W-1:0]      ent_in,
	input  wire logic [IDX_W-1:0]      slot_new_in,
	input  wire logic [IDX_W-1:0]      last_in,
	input  wire logic [CNT_W-1:0]      count_in,
	input  wire logic [DATA_WIDTH-1:0] word_in,
	input  wire logic [IDX_W-1:0]      sp_rd_data,
	input  wire logic [ENT_W-1:0]      own_rd_data,
	input  wire logic [DATA_WIDTH-1:0] wrd_rd_data,
	output wr_en_t                     wr_en,
	output logic      [ENT_W-1:0]      sp_wr_addr,
	output logic      [IDX_W-1:0]      sp_wr_data,
	output logic      [IDX_W-1:0]      own_wr_addr,
	output logic      [ENT_W-1:0]      own_wr_data,
	output logic      [IDX_W-1:0]      wrd_wr_addr,
	output logic      [DATA_WIDTH-1:0] wrd_wr_data,
	output logic                       get_rd_en,
	output logic      [IDX_W-1:0]      get_rd_addr,
	output logic                       valid_s1,
	output result_t                    result
);

	status_t               op_s1;
	logic [ENT_W-1:0]      ent_s1;
	logic [IDX_W-1:0]      slot_new_s1;
	logic [IDX_W-1:0]      last_s1;
	logic [CNT_W-1:0]      count_s1;
	logic [DATA_WIDTH-1:0] word_s1;

	wr_en_t                fwd_en_s2;
	logic [ENT_W-1:0]      fwd_sp_addr_s2;
	logic [IDX_W-1:0]      fwd_sp_data_s2;
	logic [IDX_W-1:0]      fwd_own_addr_s2;
	logic [ENT_W-1:0]      fwd_own_data_s2;
	logic [IDX_W-1:0]      fwd_wrd_addr_s2;
	logic [DATA_WIDTH-1:0] fwd_wrd_data_s2;

	wr_en_t                wr_en_c;
	logic [IDX_W-1:0]      idx;
	logic [ENT_W-1:0]      last_ent;
	logic [DATA_WIDTH-1:0] last_word;
	logic [IDX_W-1:0]      slot_c;

	// hold the request taken at the admission stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			op_s1       <= op_in;
			ent_s1      <= ent_in;
			slot_new_s1 <= slot_new_in;
			last_s1     <= last_in;
			count_s1    <= count_in;
			word_s1     <= word_in;
		end
	end

	// reads may be issued as the previous write lands: take that write instead
	assign idx = (fwd_en_s2.sparse && (fwd_sp_addr_s2 == ent_s1))
		? fwd_sp_data_s2 : sp_rd_data;
	assign last_ent = (fwd_en_s2.owner && (fwd_own_addr_s2 == last_s1))
		? fwd_own_data_s2 : own_rd_data;
	assign last_word = (fwd_en_s2.words && (fwd_wrd_addr_s2 == last_s1))
		? fwd_wrd_data_s2 : wrd_rd_data;

	// build the writes of this request
	always_comb begin
		wr_en_c     = '0;
		sp_wr_addr  = ent_s1;
		sp_wr_data  = slot_new_s1;
		own_wr_addr = slot_new_s1;
		own_wr_data = ent_s1;
		wrd_wr_addr = slot_new_s1;
		wrd_wr_data = word_s1;
		slot_c      = '0;
		case (op_s1)
			ST_ADDED: begin
				wr_en_c = '{sparse: 1'b1, owner: 1'b1, words: 1'b1};
				slot_c  = slot_new_s1;
			end
			ST_OVERWRITTEN: begin
				wr_en_c.words = 1'b1;
				wrd_wr_addr   = idx;
				slot_c        = idx;
			end
			ST_REMOVED: begin
				// move the last entry into the freed slot
				wr_en_c     = '{sparse: 1'b1, owner: 1'b1, words: 1'b1};
				sp_wr_addr  = last_ent;
				sp_wr_data  = idx;
				own_wr_addr = idx;
				own_wr_data = last_ent;
				wrd_wr_addr = idx;
				wrd_wr_data = last_word;
				slot_c      = idx;
			end
			ST_FOUND: begin
				slot_c = idx;
			end
			default: slot_c = '0;
		endcase
	end

	assign wr_en       = fire ? wr_en_c : '0;
	assign get_rd_en   = fire && (op_s1 == ST_FOUND);
	assign get_rd_addr = idx;

	assign result.status = op_s1;
	assign result.slot   = SLOT_W'(slot_c);
	assign result.count  = COUNT_W'(count_s1);

	// keep the latest write for the next request's reads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_en_s2 <= '0;
		end else if (fire) begin
			fwd_en_s2 <= wr_en_c;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			fwd_sp_addr_s2  <= sp_wr_addr;
			fwd_sp_data_s2  <= sp_wr_data;
			fwd_own_addr_s2 <= own_wr_addr;
			fwd_own_data_s2 <= own_wr_data;
			fwd_wrd_addr_s2 <= wrd_wr_addr;
			fwd_wrd_data_s2 <= wrd_wr_data;
		end
	end

endmodule

`default_nettype wire

### hdl/sparse_set_store_unit.sv
// Sparse set store: entity ids mapped to a packed dense array of data words.
// Usage:
//   Requests enter on in_valid/in_stall with mode, entity_id and data_in;
//   results leave on out_valid/out_stall with status, data_out, slot, count.
//   A request is taken at a clock edge with valid high and stall low.
// A taken request is held in the commit stage, then moved into the result register.
// Throughput: one request per cycle while no stalled result is waiting. Presence
//   and count are decided at the admission edge; each memory takes its one write in
//   the commit stage, and a one-entry bypass of that write feeds the next request.
//   A get reads its word at the commit edge through a second read port.
// Reset: arst_n clears the presence bits and the count at once, so the set
//   is empty and the block takes requests as soon as reset is released.
//   The dense memories are not cleared; only written entries reach a result or write.
// Stall: while out_stall holds a waiting result, that result holds; one more
//   request may be taken into the commit stage, after which in_stall rises.
// Depends on sss_pkg, sss_ram, sss_admit and sss_commit.
`timescale 1ns / 1ps
`default_nettype none

module sparse_set_store_unit
	import sss_pkg::*;
#(
	parameter int CAPACITY = 256,
	parameter int DATA_WIDTH = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [MODE_W-1:0]   mode,
	input  wire logic [ENT_ID_W-1:0] entity_id,
	input  wire logic [WORD_W-1:0]   data_in,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic      [STATUS_W-1:0] status,
	output logic      [WORD_W-1:0]   data_out,
	output logic      [SLOT_W-1:0]   slot,
	output logic      [COUNT_W-1:0]  count
);

	localparam int ENT_N = (CAPACITY < 256) ? CAPACITY : 256;
	localparam int ENT_W = $clog2(ENT_N);
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic                  advance;
	logic                  accept;
	logic                  fire;
	logic                  valid_s1;

	status_t               op;
	logic [ENT_W-1:0]      ent;
	logic [IDX_W-1:0]      slot_new;
	logic [IDX_W-1:0]      last;
	logic [CNT_W-1:0]      count_after;
	logic [DATA_WIDTH-1:0] word_in;

	wr_en_t                wr_en;
	logic [ENT_W-1:0]      sp_wr_addr;
	logic [IDX_W-1:0]      sp_wr_data;
	logic [IDX_W-1:0]      own_wr_addr;
	logic [ENT_W-1:0]      own_wr_data;
	logic [IDX_W-1:0]      wrd_wr_addr;
	logic [DATA_WIDTH-1:0] wrd_wr_data;
	logic                  get_rd_en;
	logic [IDX_W-1:0]      get_rd_addr;

	logic [IDX_W-1:0]      sp_rd_data;
	logic [ENT_W-1:0]      own_rd_data;
	logic [DATA_WIDTH-1:0] wrd_rd_data;
	logic [DATA_WIDTH-1:0] get_rd_data;

	result_t               result;
	result_t               result_s2;

	// handshake: commit moves on whenever the result register is free
	assign advance  = !out_valid || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;
	assign fire     = valid_s1 && advance;
	assign word_in  = DATA_WIDTH'(data_in);

	sss_admit #(
		.CAPACITY(CAPACITY)
	) u_admit (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.mode       (mode),
		.entity_id  (entity_id),
		.op         (op),
		.ent        (ent),
		.slot_new   (slot_new),
		.last       (last),
		.count_after(count_after)
	);

	sss_commit #(
		.CAPACITY  (CAPACITY),
		.DATA_WIDTH(DATA_WIDTH)
	) u_commit (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (accept),
		.fire       (fire),
		.op_in      (op),
		.ent_in     (ent),
		.slot_new_in(slot_new),
		.last_in    (last),
		.count_in   (count_after),
		.word_in    (word_in),
		.sp_rd_data (sp_rd_data),
		.own_rd_data(own_rd_data),
		.wrd_rd_data(wrd_rd_data),
		.wr_en      (wr_en),
		.sp_wr_addr (sp_wr_addr),
		.sp_wr_data (sp_wr_data),
		.own_wr_addr(own_wr_addr),
		.own_wr_data(own_wr_data),
		.wrd_wr_addr(wrd_wr_addr),
		.wrd_wr_data(wrd_wr_data),
		.get_rd_en  (get_rd_en),
		.get_rd_addr(get_rd_addr),
		.valid_s1   (valid_s1),
		.result     (result)
	);

	// entity to dense index
	sss_ram #(
		.WIDTH(IDX_W),
		.DEPTH(ENT_N)
	) u_sparse_ram (
		.clk      (clk),
		.wr_en    (wr_en.sparse),
		.wr_addr  (sp_wr_addr),
		.wr_data  (sp_wr_data),
		.rd_en_a  (accept),
		.rd_addr_a(ent),
		.rd_data_a(sp_rd_data),
		.rd_en_b  (1'b0),
		.rd_addr_b('0),
		.rd_data_b()
	);

	// dense index to owning entity
	sss_ram #(
		.WIDTH(ENT_W),
		.DEPTH(CAPACITY)
	) u_owner_ram (
		.clk      (clk),
		.wr_en    (wr_en.owner),
		.wr_addr  (own_wr_addr),
		.wr_data  (own_wr_data),
		.rd_en_a  (accept),
		.rd_addr_a(last),
		.rd_data_a(own_rd_data),
		.rd_en_b  (1'b0),
		.rd_addr_b('0),
		.rd_data_b()
	);

	// dense data words: last entry at admission, found entry at commit
	sss_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(CAPACITY)
	) u_words_ram (
		.clk      (clk),
		.wr_en    (wr_en.words),
		.wr_addr  (wrd_wr_addr),
		.wr_data  (wrd_wr_data),
		.rd_en_a  (accept),
		.rd_addr_a(last),
		.rd_data_a(wrd_rd_data),
		.rd_en_b  (get_rd_en),
		.rd_addr_b(get_rd_addr),
		.rd_data_b(get_rd_data)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (fire) begin
			out_valid <= 1'b1;
		end else if (advance) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_s2 <= result;
		end
	end

	assign status   = result_s2.status;
	assign slot     = result_s2.slot;
	assign count    = result_s2.count;
	assign data_out = (result_s2.status == ST_FOUND) ? WORD_W'(get_rd_data) : '0;

endmodule

`default_nettype wire

### hdl/sss_checker.sv
// Port-level checks of the sparse set store, bound to its top level.
// Watches the result channel and the request stall over time.
// Depends on sss_pkg and sparse_set_store_unit.
`timescale 1ns / 1ps
`default_nettype none

module sss_checker
	import sss_pkg::*;
(
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_stall,
	input wire logic                out_valid,
	input wire logic                out_stall,
	input wire logic [STATUS_W-1:0] status,
	input wire logic [WORD_W-1:0]   data_out,
	input wire logic [SLOT_W-1:0]   slot,
	input wire logic [COUNT_W-1:0]  count
);

	// hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable({status, data_out, slot, count}))
		else $error("stalled result changed");

	// no result while in reset
	a_reset: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result shown during reset");

	// a free result side never stalls requests
	a_no_stall: assert property (@(posedge clk) !out_stall |-> !in_stall)
		else $error("request stalled while result side is free");

	// absent and full results carry no slot
	a_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_ABSENT || status == ST_FULL) |-> slot == '0)
		else $error("slot set on absent or full result");

	// only a found get carries data
	a_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_FOUND |-> data_out == '0)
		else $error("data set on a result other than found");

endmodule

bind sparse_set_store_unit sss_checker u_sss_checker (.*);

`default_nettype wire
